@@ hdl/atty_pkg.sv @@
// Shared types and constants for the ANSI text stream controller.
// No dependencies; imported by atty_engine and ansi_tty_text_stream_controller.
package atty_pkg;

   // Result command codes.
   localparam logic [1:0] CMD_NONE   = 2'd0;
   localparam logic [1:0] CMD_DRAW   = 2'd1;
   localparam logic [1:0] CMD_SCROLL = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_FONT_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_FONT_HEIGHT   = 2'd1;
   localparam logic [1:0] CSR_WINDOW_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_WINDOW_HEIGHT = 2'd3;

   // Configuration reset values.
   localparam logic [6:0]  FONT_WIDTH_RESET    = 7'd8;
   localparam logic [6:0]  FONT_HEIGHT_RESET   = 7'd16;
   localparam logic [11:0] WINDOW_WIDTH_RESET  = 12'd640;
   localparam logic [11:0] WINDOW_HEIGHT_RESET = 12'd480;

   // Character codes the parser recognizes.
   localparam logic [7:0] CHAR_ESC     = 8'h1B;
   localparam logic [7:0] CHAR_LBRACK  = 8'h5B;
   localparam logic [7:0] CHAR_SGR_END = 8'h6D;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   // Color selector codes.
   localparam logic [3:0] SEL_DEFAULT_FG = 4'd8;
   localparam logic [3:0] SEL_DEFAULT_BG = 4'd9;

   // Saturation limits.
   localparam logic [12:0] X_MAX   = 13'h1FFF;
   localparam logic [6:0]  ARG_MAX = 7'd127;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       first_of_string;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  glyph_code;
      logic [12:0] draw_x;
      logic [11:0] draw_y;
      logic [3:0]  fg_select;
      logic [3:0]  bg_select;
      logic        last;
   } rsp_payload_type;

   typedef struct packed {
      logic [6:0]  font_width;
      logic [6:0]  font_height;
      logic [11:0] window_width;
      logic [11:0] window_height;
   } cfg_type;

   // Results of one byte: always a first one, optionally a second one.
   typedef struct packed {
      logic            two;
      rsp_payload_type first;
      rsp_payload_type second;
   } result_pair_type;

endpackage

@@ hdl/ansi_tty_text_stream_controller.sv @@
// Top level of the ANSI text stream controller: input register, result
// queue of two entries and configuration registers. Depends on atty_pkg, atty_engine.
//
//   Channel  Direction  Handshake                     Payload
//   req      in         req_valid / req_stall         req_payload (one text byte)
//   rsp      out        rsp_valid / rsp_stall         rsp_payload (one result)
//   csr      in         csr_write_enable              csr_index, csr_write_data
//
// Bytes that yield one result flow at one per cycle while rsp_stall is low; a
// byte that scrolls and then draws holds the next byte back until the single
// result port drains its second entry from the two-entry result queue. A byte
// waits in the input register, its results in the queue head. Reset is
// synchronous and restores the cursor, parser, colors and registers. A stalled
// result port holds the queue and then the input register, after which req_stall rises.
module ansi_tty_text_stream_controller import atty_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_write_enable,
   input  logic [1:0]      csr_index,
   input  logic [11:0]     csr_write_data
);

   // Input register: holds the byte waiting for its turn in the engine.
   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff, in_data_in;

   // Result queue: head is presented on the rsp port, tail follows it.
   logic [1:0]      out_count_ff, out_count_in;
   rsp_payload_type out_head_ff, out_head_in;
   rsp_payload_type out_tail_ff, out_tail_in;

   cfg_type         cfg_ff;
   result_pair_type results;

   logic            rsp_take;
   logic            req_take;
   logic            drain_ok;
   logic            fire;

   atty_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .item    (in_data_ff),
      .cfg     (cfg_ff),
      .results (results)
   );

   always_comb begin
      rsp_valid   = (out_count_ff != 2'd0);
      rsp_payload = out_head_ff;
      rsp_take    = rsp_valid && !rsp_stall;
      // The queue can take a new byte's results when it is empty or its
      // last entry leaves in this cycle.
      drain_ok    = (out_count_ff == 2'd0) || ((out_count_ff == 2'd1) && rsp_take);
      fire        = in_valid_ff && drain_ok;
      req_stall   = in_valid_ff && !drain_ok;
      req_take    = req_valid && !req_stall;

      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_payload;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end

      out_count_in = out_count_ff;
      out_head_in  = out_head_ff;
      out_tail_in  = out_tail_ff;
      if (fire) begin
         out_head_in  = results.first;
         out_tail_in  = results.second;
         out_count_in = results.two ? 2'd2 : 2'd1;
      end else if (rsp_take) begin
         if (out_count_ff == 2'd2) begin
            out_head_in  = out_tail_ff;
            out_count_in = 2'd1;
         end else begin
            out_count_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_count_ff <= 2'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_count_ff <= out_count_in;
      end
      in_data_ff  <= in_data_in;
      out_head_ff <= out_head_in;
      out_tail_ff <= out_tail_in;
   end

   // Configuration registers; writes must arrive only while the block is idle, which the block itself does not enforce.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.font_width    <= FONT_WIDTH_RESET;
         cfg_ff.font_height   <= FONT_HEIGHT_RESET;
         cfg_ff.window_width  <= WINDOW_WIDTH_RESET;
         cfg_ff.window_height <= WINDOW_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FONT_WIDTH:    cfg_ff.font_width    <= csr_write_data[6:0];
            CSR_FONT_HEIGHT:   cfg_ff.font_height   <= csr_write_data[6:0];
            CSR_WINDOW_WIDTH:  cfg_ff.window_width  <= csr_write_data;
            CSR_WINDOW_HEIGHT: cfg_ff.window_height <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

endmodule

@@ hdl/atty_engine.sv @@
// Terminal state (cursor, escape parser, color selectors) and the per-byte
// update logic that produces one or two results. Depends on atty_pkg.
module atty_engine import atty_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  req_payload_type item,
   input  cfg_type         cfg,
   output result_pair_type results
);

   typedef enum logic [1:0] {
      PH_TEXT,
      PH_ESC,
      PH_ARGS
   } phase_type;

   logic [12:0] cursor_x_ff, cursor_x_in;
   logic [11:0] cursor_y_ff, cursor_y_in;
   phase_type   phase_ff, phase_in;
   logic [6:0]  arg_ff, arg_in;
   logic [3:0]  fg_ff, fg_in;
   logic [3:0]  bg_ff, bg_in;

   logic [7:0]  c;
   phase_type   phase_v;
   logic [6:0]  arg_v;
   logic [7:0]  digit;
   logic [10:0] arg_next;
   logic [6:0]  code_off;
   logic [13:0] tab_sum;
   logic [13:0] adv_sum;
   logic [12:0] base_x;
   logic        fit_first;
   logic        fit_second;
   logic        scroll;
   logic        draw;
   logic [12:0] glyph_x;
   logic [11:0] glyph_y;
   rsp_payload_type scroll_res;
   rsp_payload_type draw_res;
   rsp_payload_type none_res;

   always_comb begin
      c        = item.char_byte;
      phase_v  = item.first_of_string ? PH_TEXT : phase_ff;
      arg_v    = item.first_of_string ? 7'd0 : arg_ff;
      fg_in    = item.first_of_string ? SEL_DEFAULT_FG : fg_ff;
      bg_in    = item.first_of_string ? SEL_DEFAULT_BG : bg_ff;
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      phase_in = phase_v;
      arg_in   = arg_v;
      scroll   = 1'b0;
      draw     = 1'b0;
      glyph_x  = cursor_x_ff;
      glyph_y  = cursor_y_ff;
      base_x   = cursor_x_ff;
      fit_second = 1'b0;

      digit    = c - CHAR_ZERO;
      arg_next = {4'd0, arg_v} * 11'd10 + {7'd0, digit[3:0]};
      code_off = arg_v - 7'd30;
      tab_sum  = {1'b0, cursor_x_ff} + 14'd8;
      fit_first = (({1'b0, cursor_x_ff} + {7'd0, cfg.font_width}) < {2'd0, cfg.window_width})
               && (({1'b0, cursor_y_ff} + {6'd0, cfg.font_height}) < {1'b0, cfg.window_height});

      case (phase_v)
         PH_ESC: begin
            phase_in = (c == CHAR_LBRACK) ? PH_ARGS : PH_TEXT;
            arg_in   = 7'd0;
            if (c != CHAR_LBRACK) begin
               arg_in = arg_v;
            end
         end
         PH_ARGS: begin
            if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
               arg_in = (arg_next > {4'd0, ARG_MAX}) ? ARG_MAX : arg_next[6:0];
            end else begin
               phase_in = PH_TEXT;
               if (c == CHAR_SGR_END) begin
                  // Select graphic rendition: only color codes take effect.
                  if (arg_v == 7'd0) begin
                     fg_in = SEL_DEFAULT_FG;
                     bg_in = SEL_DEFAULT_BG;
                  end else if (arg_v == 7'd7) begin
                     fg_in = SEL_DEFAULT_BG;
                     bg_in = SEL_DEFAULT_FG;
                  end else if (arg_v inside {[7'd30:7'd37]}) begin
                     fg_in = code_off[3:0];
                  end else if (arg_v inside {7'd38, 7'd39}) begin
                     fg_in = SEL_DEFAULT_FG;
                  end else if (arg_v inside {[7'd40:7'd47]}) begin
                     bg_in = code_off[3:0] - 4'd10;
                  end else if (arg_v inside {7'd48, 7'd49}) begin
                     bg_in = SEL_DEFAULT_BG;
                  end
               end
            end
         end
         default: begin
            case (c)
               CHAR_LF: begin
                  cursor_x_in = 13'd0;
                  if (cursor_y_ff <= {5'd0, cfg.font_height}) begin
                     scroll = 1'b1;
                  end else begin
                     cursor_y_in = cursor_y_ff - {5'd0, cfg.font_height};
                  end
               end
               CHAR_CR: begin
                  cursor_x_in = 13'd0;
               end
               CHAR_TAB: begin
                  cursor_x_in = tab_sum[13] ? X_MAX : {tab_sum[12:3], 3'd0};
               end
               CHAR_ESC: begin
                  phase_in = PH_ESC;
               end
               default: begin
                  if (fit_first) begin
                     draw = 1'b1;
                  end else begin
                     // Wrap to a new line first, scrolling on the bottom line.
                     base_x = 13'd0;
                     if (cursor_y_ff <= {5'd0, cfg.font_height}) begin
                        scroll = 1'b1;
                     end else begin
                        cursor_y_in = cursor_y_ff - {5'd0, cfg.font_height};
                     end
                     fit_second = ({7'd0, cfg.font_width} < {2'd0, cfg.window_width})
                        && (({1'b0, cursor_y_in} + {6'd0, cfg.font_height})
                            < {1'b0, cfg.window_height});
                     draw = fit_second;
                  end
                  glyph_x = base_x;
                  glyph_y = cursor_y_in;
               end
            endcase
         end
      endcase

      adv_sum = {1'b0, base_x} + {7'd0, cfg.font_width};
      if (phase_v == PH_TEXT && !(c inside {CHAR_LF, CHAR_CR, CHAR_TAB, CHAR_ESC})) begin
         cursor_x_in = adv_sum[13] ? X_MAX : adv_sum[12:0];
      end

      scroll_res = '{command: CMD_SCROLL, glyph_code: 8'd0, draw_x: 13'd0, draw_y: 12'd0,
                     fg_select: fg_in, bg_select: bg_in, last: !draw};
      draw_res   = '{command: CMD_DRAW, glyph_code: c, draw_x: glyph_x, draw_y: glyph_y,
                     fg_select: fg_in, bg_select: bg_in, last: 1'b1};
      none_res   = '{command: CMD_NONE, glyph_code: 8'd0, draw_x: cursor_x_in,
                     draw_y: cursor_y_in, fg_select: fg_in, bg_select: bg_in, last: 1'b1};

      results.two    = scroll && draw;
      results.second = draw_res;
      if (scroll) begin
         results.first = scroll_res;
      end else if (draw) begin
         results.first = draw_res;
      end else begin
         results.first = none_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff <= 13'd0;
         cursor_y_ff <= 12'd0;
         phase_ff    <= PH_TEXT;
         arg_ff      <= 7'd0;
         fg_ff       <= SEL_DEFAULT_FG;
         bg_ff       <= SEL_DEFAULT_BG;
      end else if (fire) begin
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
         phase_ff    <= phase_in;
         arg_ff      <= arg_in;
         fg_ff       <= fg_in;
         bg_ff       <= bg_in;
      end
   end

endmodule
